// File: rtl/bmb_pkg.sv
`default_nettype none
package bmb_pkg;

	localparam int unsigned FB_DIM_W = 9;
	localparam int unsigned BM_DIM_W = 12;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [FB_DIM_W-1:0] MAX_FB_WIDTH   = 9'd256;
	localparam logic [FB_DIM_W-1:0] MAX_FB_HEIGHT  = 9'd256;
	localparam logic [BM_DIM_W-1:0] MAX_BITMAP_DIM = 12'd4095;

	localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_VALUE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE     = 3'd7;

	typedef struct packed {
		logic                start;
		logic [7:0]          bits;
		logic [BM_DIM_W:0]   idx;
		logic [BM_DIM_W-1:0] bw;
		logic [COORD_W-1:0]  x0;
		logic [FB_DIM_W-1:0] col0;
		logic [ADDR_W-1:0]   rowbase;
		logic [FB_DIM_W-1:0] fw;
		logic [PIX_W-1:0]    value;
		logic                en;
		logic                clip;
	} scan_cmd_t;

endpackage
`default_nettype wire

// File: rtl/mono_bitmap_blit_to_8bit_framebuffer.sv
// Monochrome bitmap blit into an 8-bit framebuffer.
// Input channel s_axis: one bitmap byte per item, bit 7 is the leftmost pixel;
// rows are padded to whole bytes. Output channel m_axis: one pixel write per
// item, address in tdata[15:0], value in tdata[23:16], tlast marks the final
// write caused by an input byte. A byte with no drawn pixel yields no items.
// Configuration channel cfg: cfg_index selects the register (fb_width,
// fb_height, origin_x, origin_y, bitmap_width, bitmap_height, draw_value,
// clip_mode in that order), cfg_data carries the value; cfg_ready is always
// high. Write it only while no byte is in flight.
// Each byte goes through setup: a bit-serial modulo of the column and row
// against the framebuffer size, then a done step and a multiply step for the
// row base. The scan then checks the bitmap bits, up to 8, plus a flush step.
// s_axis_tready is high only between bytes.
// A stalled receiver holds the output register; the scan waits until the
// held write is taken. The next byte is accepted while the last write of the
// previous one still waits in the output register.
// Reset restores the register defaults (128, 64, 0, 0, 8, 8, 255, 0) and
// returns the bitmap position to the top-left corner.
`default_nettype none
module mono_bitmap_blit_to_8bit_framebuffer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [7:0]                         s_axis_tdata,  // [7:0] bitmap_byte
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [23:0]                             m_axis_tdata,  // [15:0] pixel_address, [23:16] pixel_value
	output logic                                    m_axis_tlast,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bmb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bmb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bmb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0]          state_q;
	logic [FB_DIM_W-1:0] fb_width_q;
	logic [FB_DIM_W-1:0] fb_height_q;
	logic [COORD_W-1:0]  origin_x_q;
	logic [COORD_W-1:0]  origin_y_q;
	logic [BM_DIM_W-1:0] bitmap_width_q;
	logic [BM_DIM_W-1:0] bitmap_height_q;
	logic [PIX_W-1:0]    draw_value_q;
	logic                clip_mode_q;
	logic [BM_DIM_W-1:0] column_count_q;
	logic [BM_DIM_W-1:0] row_count_q;
	logic [7:0]          byte_q;
	logic [BM_DIM_W-1:0] colstart_q;
	logic [COORD_W-1:0]  x0_q;
	logic [COORD_W-1:0]  y_q;

	logic                accept;
	logic [FB_DIM_W-1:0] fw;
	logic [FB_DIM_W-1:0] fh;
	logic [BM_DIM_W-1:0] bw;
	logic [BM_DIM_W-1:0] bh;
	logic [COORD_W-1:0]  x0_c;
	logic [COORD_W-1:0]  y_c;
	logic [BM_DIM_W:0]   col_next;
	logic [BM_DIM_W:0]   row_next;
	logic                xmod_done;
	logic                ymod_done;
	logic [FB_DIM_W-1:0] xmod;
	logic [FB_DIM_W-1:0] ymod;
	logic [2*FB_DIM_W-1:0] prod;
	logic                scan_done;
	scan_cmd_t           cmd;

	always_comb begin
		accept = s_axis_tvalid && s_axis_tready;
		fw = (fb_width_q > MAX_FB_WIDTH) ? MAX_FB_WIDTH : fb_width_q;
		fh = (fb_height_q > MAX_FB_HEIGHT) ? MAX_FB_HEIGHT : fb_height_q;
		if (bitmap_width_q == '0) begin
			bw = BM_DIM_W'(1);
		end else if (bitmap_width_q > MAX_BITMAP_DIM) begin
			bw = MAX_BITMAP_DIM;
		end else begin
			bw = bitmap_width_q;
		end
		if (bitmap_height_q == '0) begin
			bh = BM_DIM_W'(1);
		end else if (bitmap_height_q > MAX_BITMAP_DIM) begin
			bh = MAX_BITMAP_DIM;
		end else begin
			bh = bitmap_height_q;
		end
		x0_c     = origin_x_q + COORD_W'(column_count_q);
		y_c      = origin_y_q + COORD_W'(row_count_q);
		col_next = {1'b0, column_count_q} + (BM_DIM_W+1)'(8);
		row_next = {1'b0, row_count_q} + 1'b1;
		prod     = ymod * fw;
	end

	always_comb begin
		cmd.start   = (state_q == ST_MUL);
		cmd.bits    = byte_q;
		cmd.idx     = {1'b0, colstart_q};
		cmd.bw      = bw;
		cmd.x0      = x0_q;
		cmd.col0    = xmod;
		cmd.rowbase = prod[ADDR_W-1:0];
		cmd.fw      = fw;
		cmd.value   = draw_value_q;
		cmd.en      = (fw != '0) && (fh != '0) &&
			!(clip_mode_q && (y_q >= COORD_W'(fh)));
		cmd.clip    = clip_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			fb_width_q      <= 9'd128;
			fb_height_q     <= 9'd64;
			origin_x_q      <= '0;
			origin_y_q      <= '0;
			bitmap_width_q  <= 12'd8;
			bitmap_height_q <= 12'd8;
			draw_value_q    <= 8'hFF;
			clip_mode_q     <= 1'b0;
			column_count_q  <= '0;
			row_count_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FB_WIDTH:      fb_width_q      <= cfg_data[FB_DIM_W-1:0];
					REG_FB_HEIGHT:     fb_height_q     <= cfg_data[FB_DIM_W-1:0];
					REG_ORIGIN_X:      origin_x_q      <= cfg_data[COORD_W-1:0];
					REG_ORIGIN_Y:      origin_y_q      <= cfg_data[COORD_W-1:0];
					REG_BITMAP_WIDTH:  bitmap_width_q  <= cfg_data[BM_DIM_W-1:0];
					REG_BITMAP_HEIGHT: bitmap_height_q <= cfg_data[BM_DIM_W-1:0];
					REG_DRAW_VALUE:    draw_value_q    <= cfg_data[PIX_W-1:0];
					REG_CLIP_MODE:     clip_mode_q     <= cfg_data[0];
					default:           clip_mode_q     <= clip_mode_q;
				endcase
			end
			if (accept) begin
				if (col_next >= {1'b0, bw}) begin
					column_count_q <= '0;
					if (row_next >= {1'b0, bh}) begin
						row_count_q <= '0;
					end else begin
						row_count_q <= row_next[BM_DIM_W-1:0];
					end
				end else begin
					column_count_q <= col_next[BM_DIM_W-1:0];
				end
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MOD;
				ST_MOD:  if (xmod_done && ymod_done) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SCAN;
				ST_SCAN: if (scan_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q     <= s_axis_tdata;
			colstart_q <= column_count_q;
			x0_q       <= x0_c;
			y_q        <= y_c;
		end
	end

	bmb_mod_serial u_xmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (x0_c),
		.divisor   (fw),
		.done      (xmod_done),
		.remainder (xmod)
	);

	bmb_mod_serial u_ymod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (y_c),
		.divisor   (fh),
		.done      (ymod_done),
		.remainder (ymod)
	);

	bmb_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.done      (scan_done),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_addr  (m_axis_tdata[15:0]),
		.out_value (m_axis_tdata[23:16]),
		.out_last  (m_axis_tlast)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire

// File: rtl/bmb_mod_serial.sv
`default_nettype none
module bmb_mod_serial (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [bmb_pkg::COORD_W-1:0]    dividend,
	input  wire logic [bmb_pkg::FB_DIM_W-1:0]   divisor,
	output logic                                done,
	output logic [bmb_pkg::FB_DIM_W-1:0]        remainder
);
	import bmb_pkg::*;

	localparam int unsigned CNT_W = $clog2(COORD_W);

	logic [COORD_W-1:0]  dvd_q;
	logic [FB_DIM_W-1:0] dvs_q;
	logic [FB_DIM_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [FB_DIM_W:0]   r2;
	logic [FB_DIM_W:0]   rnext;

	always_comb begin
		r2 = {rem_q, dvd_q[COORD_W-1]};
		if (r2 >= {1'b0, dvs_q}) begin
			rnext = r2 - {1'b0, dvs_q};
		end else begin
			rnext = r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			rem_q <= rnext[FB_DIM_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// File: rtl/bmb_scan.sv
`default_nettype none
module bmb_scan (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bmb_pkg::scan_cmd_t   cmd,
	output logic                      done,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [bmb_pkg::ADDR_W-1:0] out_addr,
	output logic [bmb_pkg::PIX_W-1:0]  out_value,
	output logic                      out_last
);
	import bmb_pkg::*;

	logic                act_q;
	logic [7:0]          bits_q;
	logic [BM_DIM_W:0]   idx_q;
	logic [3:0]          cnt_q;
	logic [BM_DIM_W-1:0] bw_q;
	logic [COORD_W-1:0]  x_q;
	logic [FB_DIM_W-1:0] col_q;
	logic [ADDR_W-1:0]   rowbase_q;
	logic [FB_DIM_W-1:0] fw_q;
	logic [PIX_W-1:0]    value_q;
	logic                en_q;
	logic                clip_q;
	logic                pend_v_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	logic                out_v_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [PIX_W-1:0]    out_value_q;
	logic                out_last_q;

	logic              end_c;
	logic              emit_c;
	logic              out_free;
	logic              need_move;
	logic              stall;
	logic [ADDR_W-1:0] addr_c;
	logic [FB_DIM_W:0] col_inc;

	always_comb begin
		end_c     = cnt_q[3] || (idx_q >= {1'b0, bw_q});
		emit_c    = act_q && !end_c && bits_q[7] && en_q &&
			!(clip_q && (x_q >= COORD_W'(fw_q)));
		out_free  = !out_v_q || out_ready;
		need_move = act_q && (end_c || emit_c) && pend_v_q;
		stall     = need_move && !out_free;
		addr_c    = rowbase_q + ADDR_W'(col_q);
		col_inc   = {1'b0, col_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (need_move && !stall) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.start) begin
				act_q    <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (act_q && !stall) begin
				if (end_c) begin
					act_q    <= 1'b0;
					pend_v_q <= 1'b0;
				end else if (emit_c) begin
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (need_move && !stall) begin
			out_addr_q  <= pend_addr_q;
			out_value_q <= value_q;
			out_last_q  <= end_c;
		end
		if (cmd.start) begin
			bits_q    <= cmd.bits;
			idx_q     <= cmd.idx;
			cnt_q     <= '0;
			bw_q      <= cmd.bw;
			x_q       <= cmd.x0;
			col_q     <= cmd.col0;
			rowbase_q <= cmd.rowbase;
			fw_q      <= cmd.fw;
			value_q   <= cmd.value;
			en_q      <= cmd.en;
			clip_q    <= cmd.clip;
		end else if (act_q && !stall && !end_c) begin
			if (emit_c) begin
				pend_addr_q <= addr_c;
			end
			bits_q <= {bits_q[6:0], 1'b0};
			idx_q  <= idx_q + 1'b1;
			cnt_q  <= cnt_q + 1'b1;
			x_q    <= x_q + 1'b1;
			if (x_q == {COORD_W{1'b1}} || col_inc == {1'b0, fw_q}) begin
				col_q <= '0;
			end else begin
				col_q <= col_inc[FB_DIM_W-1:0];
			end
		end
	end

	assign done      = act_q && end_c && !stall;
	assign out_valid = out_v_q;
	assign out_addr  = out_addr_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/bmb_checker.sv
`default_nettype none
module bmb_assertions (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	else $error("output item changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
	else $error("configuration write refused");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
	else $error("input taken while a byte is still in flight");

endmodule

bind mono_bitmap_blit_to_8bit_framebuffer bmb_assertions u_bmb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
`default_nettype wire

// File: tb/bmb_checker.sv
`timescale 1ns / 1ps
module bmb_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] bitmap_byte
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [23:0]                    m_axis_tdata,  // [15:0] pixel_address, [23:16] pixel_value
	input  wire logic                           m_axis_tlast,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [bmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bmb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  mismatch_count,
	output int                                  pending_writes
);
	import bmb_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
		logic              last;
	} pix_write_t;

	pix_write_t expected_writes[$];

	logic [FB_DIM_W-1:0] fb_w, fb_h;
	logic [COORD_W-1:0]  org_x, org_y;
	logic [BM_DIM_W-1:0] bm_w, bm_h;
	logic [PIX_W-1:0]    ink;
	logic                clip;
	logic [BM_DIM_W-1:0] col_pos, row_pos;

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_FB_WIDTH:      fb_w = value[FB_DIM_W-1:0];
			REG_FB_HEIGHT:     fb_h = value[FB_DIM_W-1:0];
			REG_ORIGIN_X:      org_x = value[COORD_W-1:0];
			REG_ORIGIN_Y:      org_y = value[COORD_W-1:0];
			REG_BITMAP_WIDTH:  bm_w = value[BM_DIM_W-1:0];
			REG_BITMAP_HEIGHT: bm_h = value[BM_DIM_W-1:0];
			REG_DRAW_VALUE:    ink = value[PIX_W-1:0];
			REG_CLIP_MODE:     clip = value[0];
			default: ;
		endcase
	endtask

	task automatic expand_byte(input logic [7:0] pattern);
		int fw, fh, bw, bh, x, y, i, n, col, row;
		pix_write_t w;
		fw = int'((fb_w > MAX_FB_WIDTH) ? MAX_FB_WIDTH : fb_w);
		fh = int'((fb_h > MAX_FB_HEIGHT) ? MAX_FB_HEIGHT : fb_h);
		bw = (bm_w == 0) ? 1 : int'(bm_w);
		bh = (bm_h == 0) ? 1 : int'(bm_h);
		y = (int'(org_y) + int'(row_pos)) & 32'hFFFF;
		n = 0;
		for (int b = 0; b < 8; b++) begin
			i = int'(col_pos) + b;
			if (i >= bw)
				break;
			if (pattern[7-b] && fw != 0 && fh != 0) begin
				x = (int'(org_x) + i) & 32'hFFFF;
				if (!(clip && (x >= fw || y >= fh))) begin
					w.addr = ADDR_W'(((y % fh) * fw + (x % fw)) & 32'hFFFF);
					w.value = ink;
					w.last = 1'b0;
					expected_writes.push_back(w);
					n++;
				end
			end
		end
		if (n > 0)
			expected_writes[expected_writes.size()-1].last = 1'b1;
		col = int'(col_pos) + 8;
		row = int'(row_pos);
		if (col >= bw) begin
			col = 0;
			row = int'(row_pos) + 1;
			if (row >= bh)
				row = 0;
		end
		col_pos = col[BM_DIM_W-1:0];
		row_pos = row[BM_DIM_W-1:0];
	endtask

	task automatic check_write();
		pix_write_t w;
		if (expected_writes.size() == 0) begin
			$error("unexpected pixel write: address %0d value %0d last %0d",
				m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tlast);
			mismatch_count++;
		end else begin
			w = expected_writes.pop_front();
			if (m_axis_tdata[15:0] !== w.addr) begin
				$error("pixel_address: expected %0d, got %0d", w.addr, m_axis_tdata[15:0]);
				mismatch_count++;
			end
			if (m_axis_tdata[23:16] !== w.value) begin
				$error("pixel_value: expected %0d, got %0d", w.value, m_axis_tdata[23:16]);
				mismatch_count++;
			end
			if (m_axis_tlast !== w.last) begin
				$error("last_in_byte: expected %0d, got %0d", w.last, m_axis_tlast);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_w = 9'd128;
			fb_h = 9'd64;
			org_x = '0;
			org_y = '0;
			bm_w = 12'd8;
			bm_h = 12'd8;
			ink = 8'd255;
			clip = 1'b0;
			col_pos = '0;
			row_pos = '0;
			expected_writes.delete();
			mismatch_count = 0;
			pending_writes <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready)
				check_write();
			if (s_axis_tvalid && s_axis_tready)
				expand_byte(s_axis_tdata);
			pending_writes <= expected_writes.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import bmb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FB_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatch_count;
	int                    pending_writes;

	logic tx_idle_on = 1'b1;
	logic rx_idle_on = 1'b1;
	logic rx_hold_req = 1'b0;
	logic rx_hold_done = 1'b0;
	int   cycle_count = 0;

	mono_bitmap_blit_to_8bit_framebuffer DUT (.*);

	bmb_checker checker_i (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (rx_hold_req && !rx_hold_done) begin
				m_axis_tready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				rx_hold_done = 1'b1;
			end else begin
				m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 21);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input int fw, input int fh, input int ox, input int oy,
			input int bw, input int bh, input int dv, input int clip);
		write_reg(REG_FB_WIDTH, CFG_DATA_W'(fw));
		write_reg(REG_FB_HEIGHT, CFG_DATA_W'(fh));
		write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
		write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
		write_reg(REG_BITMAP_WIDTH, CFG_DATA_W'(bw));
		write_reg(REG_BITMAP_HEIGHT, CFG_DATA_W'(bh));
		write_reg(REG_DRAW_VALUE, CFG_DATA_W'(dv));
		write_reg(REG_CLIP_MODE, CFG_DATA_W'(clip));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] pattern);
		if (tx_idle_on && $urandom_range(0, 99) < 21) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pattern;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop valid, wait out all pixel writes, then let the last byte settle
	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_fb_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(257, 511);
			2: return 256;
			3: return 1;
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	function automatic int pick_origin();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(65500, 65535);
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	function automatic int pick_bm_dim(input int typical);
		case ($urandom_range(0, 11))
			0: return 0;
			1: return 4095;
			2: return $urandom_range(1, 4095);
			default: return $urandom_range(1, typical);
		endcase
	endfunction

	function automatic logic [7:0] pick_pattern();
		case ($urandom_range(0, 7))
			0: return 8'hFF;
			1: return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);
		finish_phase();

		// padded row, wrapping origin, row already past the new height
		set_config(256, 256, 16'hFFFC, 16'hFFFF, 12, 2, 0, 0);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_byte(8'h55);
		finish_phase();

		// clip at right and bottom edges, oversized width clamped
		set_config(511, 62, 250, 60, 16, 4, 8'hA5, 1);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hC3);
		finish_phase();

		set_config(0, 64, 0, 0, 8, 8, 255, 0);
		send_byte(8'hFF);
		send_byte(8'h7E);
		finish_phase();
		set_config(200, 0, 0, 0, 8, 8, 255, 1);
		send_byte(8'hFF);
		finish_phase();

		// zero bitmap size acts as one pixel, single-pixel framebuffer
		set_config(1, 1, 0, 0, 0, 0, 8'h3C, 0);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h80);
		finish_phase();

		set_config(256, 256, 0, 0, 4095, 4095, 255, 0);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'hFF);
		finish_phase();

		for (int p = 0; p < 8; p++) begin
			// the held-off phase draws every set bit so the block backs up
			if (p == 5)
				set_config(256, 256, 0, 0, 24, 6, 8'h5A, 0);
			else
				set_config(pick_fb_dim(), pick_fb_dim(), pick_origin(), pick_origin(),
					pick_bm_dim(24), pick_bm_dim(6), $urandom_range(0, 255),
					$urandom_range(0, 1));
			tx_idle_on = (p != 2);
			rx_idle_on = (p != 2);
			if (p == 5)
				rx_hold_req = 1'b1;
			for (int k = 0; k < 24; k++)
				send_byte(pick_pattern());
			finish_phase();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
